### hw/rtl/sitda_pkg.sv
// Package: types, constants and helpers for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

package sitda_pkg;

	localparam int VALUE_W    = 32;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int CNT_W      = $clog2(VALUE_W);

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} state_t;

	// add 3 to every BCD digit of 5 or more, ahead of the left shift
	function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
		logic [BCD_W-1:0] res;
		res = bcd;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd[4*i +: 4] >= 4'd5) begin
				res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
			end
		end
		return res;
	endfunction

endpackage

### hw/rtl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII character stream.
`timescale 1ns / 1ps

// Converts one signed 32-bit value per transfer into its decimal text, most
// significant character first, a leading '-' for negative values, no leading
// zeros, and last set on the final character. One value is worked on at a time:
// a transfer is taken only when the converter is idle. The magnitude goes
// through a bit-serial shift-and-add-3 binary to BCD loop over all 32 bits, then
// leading zero digits are dropped at one per cycle and each character is sent
// through a one-entry output register, one per cycle when the sink is ready.
// An item goes through loading, the conversion loop, the '-' character when
// negative, the skipped leading zeros, the step out of the skip and then one
// character per digit, while the last character can still wait at the output
// as the next value is accepted.
module signed_int_to_decimal_ascii (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sitda_pkg::VALUE_W-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    character,
	output logic                          last
);
	import sitda_pkg::*;

	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [VALUE_W-1:0]     mag_q, mag_d;
	logic [BCD_W-1:0]       bcd_q, bcd_d;
	logic                   neg_q, neg_d;
	logic                   ovalid_q, ovalid_d;
	logic [7:0]             char_q, char_d;
	logic                   last_q, last_d;
	logic                   can_load;
	logic [BCD_W-1:0]       bcd_adj;
	logic [3:0]             top_digit;

	assign can_load  = !ovalid_q || out_ready;
	assign bcd_adj   = bcd_adjust(bcd_q);
	assign top_digit = bcd_q[BCD_W-1 -: 4];

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ovalid_q;
	assign character = char_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			neg_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			neg_q    <= neg_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_ff @(posedge clk) begin
		mag_q  <= mag_d;
		bcd_q  <= bcd_d;
		char_q <= char_d;
		last_q <= last_d;
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		mag_d    = mag_q;
		bcd_d    = bcd_q;
		neg_d    = neg_q;
		char_d   = char_q;
		last_d   = last_q;
		ovalid_d = ovalid_q && !out_ready;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					neg_d   = value[VALUE_W-1];
					mag_d   = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
					bcd_d   = '0;
					cnt_d   = '0;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				{bcd_d, mag_d} = {bcd_adj[BCD_W-2:0], mag_q, 1'b0};
				if (cnt_q == CNT_W'(VALUE_W - 1)) begin
					cnt_d   = CNT_W'(NUM_DIGITS - 1);
					state_d = neg_q ? ST_SIGN : ST_SKIP;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			ST_SIGN: begin
				if (can_load) begin
					char_d   = CHAR_MINUS;
					last_d   = 1'b0;
					ovalid_d = 1'b1;
					state_d  = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (top_digit == 4'd0 && cnt_q != '0) begin
					bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
					cnt_d = cnt_q - CNT_W'(1);
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (can_load) begin
					char_d   = CHAR_ZERO + {4'd0, top_digit};
					last_d   = (cnt_q == '0);
					ovalid_d = 1'b1;
					bcd_d    = {bcd_q[BCD_W-5:0], 4'd0};
					if (cnt_q == '0) begin
						state_d = ST_IDLE;
					end else begin
						cnt_d = cnt_q - CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_digit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> top_digit <= 4'd9)
		else $error("non-decimal digit at emit");

	a_sign_only_neg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SIGN |-> neg_q)
		else $error("sign state on non-negative value");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP || state_q == ST_EMIT) |-> cnt_q <= CNT_W'(NUM_DIGITS - 1))
		else $error("digit count out of range");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && char_q == CHAR_MINUS |-> !last_q)
		else $error("minus sign flagged as last");
`endif

endmodule
